// ===== rtl/assert_macros.svh =====
// assertion helpers for the threshold extent distance block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`ASSERT_ALWAYS(lbl, clk, rstn, !(cond), msg)

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== rtl/ted_pkg.sv =====
package ted_pkg;

	// fixed field widths
	localparam int PIX_W   = 8;
	localparam int PWID_W  = 12;
	localparam int OBJ_W   = 16;
	localparam int FOCAL_W = 12;
	localparam int DIST_W  = OBJ_W + FOCAL_W;
	localparam int OUT_W   = PWID_W + DIST_W;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 2;

	// one quotient bit per divide step
	localparam int DIV_STEPS = DIST_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// job queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CIDX_W-1:0] REG_OBJ_WIDTH = 2'd1;
	localparam logic [CIDX_W-1:0] REG_FOCAL     = 2'd2;

	// register reset values
	localparam logic [PIX_W-1:0]   THRESHOLD_RST = 8'd30;
	localparam logic [OBJ_W-1:0]   OBJ_WIDTH_RST = 16'd1280;
	localparam logic [FOCAL_W-1:0] FOCAL_RST     = 12'd400;

	typedef struct packed {
		logic [PIX_W-1:0]   threshold;
		logic [OBJ_W-1:0]   obj_width;
		logic [FOCAL_W-1:0] focal;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [PWID_W-1:0] width;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} back_state_t;

endpackage

// ===== rtl/threshold_extent_distance_core.sv =====
// a frame end transaction passes through the back end states in order
// (pop, multiply, 28 divide steps, output); a frame with no object skips multiply and divide
// throughput: one pixel per cycle while s_tready is high; a found object holds the back end through multiply and divide
// input stalls only when two frame results are already queued behind the divider
// reset: arst_n asynchronous active low; registers go to 30, 1280, 400, extent and queue clear
module threshold_extent_distance_core #(
	parameter int LINE_WIDTH = 640
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] pixel
	input  logic                        s_tuser,  // [0] line_end
	input  logic                        s_tlast,  // frame_end
	// frame result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata,  // [11:0] pixel_width, [39:12] distance_q8
	output logic                        m_tuser,  // [0] object_found
	// configuration writes
	input  logic                        cfg_we,
	input  logic [ted_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [ted_pkg::CFG_W-1:0]   cfg_wdata
);
	import ted_pkg::*;

	cfg_t      cfg_q;
	logic      s_accept;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head_job;
	q_status_t q_status;

	// configuration registers, unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.obj_width <= OBJ_WIDTH_RST;
			cfg_q.focal     <= FOCAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_wdata[PIX_W-1:0];
				REG_OBJ_WIDTH: cfg_q.obj_width <= cfg_wdata[OBJ_W-1:0];
				REG_FOCAL:     cfg_q.focal     <= cfg_wdata[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	// hold pixels back while no queue slot is free for a frame result
	assign s_tready = !q_status.full;
	assign s_accept = s_tvalid && s_tready;

	// front end: column count and bright extent per frame
	ted_front #(
		.LINE_WIDTH(LINE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.pixel     (s_tdata),
		.line_end  (s_tuser),
		.frame_end (s_tlast),
		.threshold (cfg_q.threshold),
		.push      (push),
		.job       (push_job)
	);

	// short queue of frame jobs
	ted_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.status (q_status)
	);

	// back end: multiply, serial divide, output register
	ted_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (head_job),
		.q_status (q_status),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

`include "assert_macros.svh"

	// a frame result never arrives at a full queue
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && q_status.full, "frame job pushed into full queue")
	// the back end never pops an empty queue
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && q_status.empty, "job popped from empty queue")
	// a missing object reports zero width and distance
	`ASSERT_NEVER(a_none_zero, clk, arst_n, m_tvalid && !m_tuser && (m_tdata != '0), "empty result nonzero")
	// a found object has a nonzero width
	`ASSERT_NEVER(a_found_width, clk, arst_n, m_tvalid && m_tuser && (m_tdata[11:0] == '0), "zero width found")

endmodule

// ===== rtl/ted_front.sv =====
module ted_front #(
	parameter int LINE_WIDTH = 640
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [ted_pkg::PIX_W-1:0]    pixel,
	input  logic                         line_end,
	input  logic                         frame_end,
	input  logic [ted_pkg::PIX_W-1:0]    threshold,
	output logic                         push,
	output ted_pkg::job_t                job
);
	import ted_pkg::*;

	localparam int CW = $clog2(LINE_WIDTH);
	localparam int LW = $clog2(LINE_WIDTH + 1);

	logic [CW-1:0] column_q;
	logic [LW-1:0] least_q;
	logic [CW-1:0] greatest_q;
	logic          bright;
	logic [LW-1:0] least_nx;
	logic [CW-1:0] greatest_nx;
	logic          found;
	logic [CW-1:0] wdiff;

	always_comb begin
		bright      = pixel > threshold;
		least_nx    = least_q;
		greatest_nx = greatest_q;
		if (bright && (LW'(column_q) < least_q)) begin
			least_nx = LW'(column_q);
		end
		if (bright && (column_q > greatest_q)) begin
			greatest_nx = column_q;
		end
		found = least_nx < LW'(greatest_nx);
		wdiff = greatest_nx - least_nx[CW-1:0];
	end

	assign push      = accept && frame_end;
	assign job.found = found;
	assign job.width = found ? PWID_W'(wdiff) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			least_q    <= LW'(LINE_WIDTH);
			greatest_q <= '0;
		end else if (accept) begin
			if (line_end || frame_end) begin
				column_q <= '0;
			end else if (column_q < CW'(LINE_WIDTH - 1)) begin
				column_q <= column_q + 1'b1;
			end
			if (frame_end) begin
				least_q    <= LW'(LINE_WIDTH);
				greatest_q <= '0;
			end else begin
				least_q    <= least_nx;
				greatest_q <= greatest_nx;
			end
		end
	end

endmodule

// ===== rtl/ted_queue.sv =====
module ted_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ted_pkg::job_t       wr_job,
	input  logic                pop,
	output ted_pkg::job_t       rd_job,
	output ted_pkg::q_status_t  status
);
	import ted_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.empty = count_q == '0;
	assign status.full  = count_q == QCNT_W'(QDEPTH);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_job       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ted_back.sv =====
module ted_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ted_pkg::cfg_t               cfg,
	input  ted_pkg::job_t               job,
	input  ted_pkg::q_status_t          q_status,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ted_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tuser
);
	import ted_pkg::*;

	back_state_t        state_q;
	back_state_t        state_nx;
	logic [DIST_W-1:0]  quo_q;
	logic [PWID_W-1:0]  rem_q;
	logic [PWID_W-1:0]  div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               found_q;
	logic [PWID_W:0]    trial;
	logic               ge;

	// restoring divide step, quotient shifts into the dividend register
	assign trial = {rem_q, quo_q[DIST_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					pop      = 1'b1;
					state_nx = job.found ? BK_MUL : BK_OUT;
				end
			end
			BK_MUL: state_nx = BK_DIV;
			BK_DIV: begin
				if (cnt_q == '0) begin
					state_nx = BK_OUT;
				end
			end
			BK_OUT: begin
				if (m_tready) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				found_q <= job.found;
				div_q   <= job.width;
				quo_q   <= '0;
				rem_q   <= '0;
				cnt_q   <= CNT_W'(DIV_STEPS - 1);
			end
			BK_MUL: quo_q <= DIST_W'(cfg.obj_width) * DIST_W'(cfg.focal);
			BK_DIV: begin
				quo_q <= {quo_q[DIST_W-2:0], ge};
				rem_q <= ge ? PWID_W'(trial - {1'b0, div_q}) : trial[PWID_W-1:0];
				cnt_q <= cnt_q - 1'b1;
			end
			BK_OUT: ;
			default: ;
		endcase
	end

	assign m_tvalid = state_q == BK_OUT;
	assign m_tuser  = found_q;
	assign m_tdata  = {quo_q, div_q};

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import ted_pkg::*;

	// block parameter, also used by the local extent tracker
	localparam int LINE_W = 640;

	// cycles after the last expected result before the block counts as idle
	localparam int SETTLE = 48;
	// random part: pixel budget over all frames
	localparam int ITEM_TARGET = 1100;
	// hard stop, far beyond the slowest legal run
	localparam longint TIMEOUT = 64'd40_000_000;

	// the index past the register list, writes to it are dropped
	localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [CIDX_W-1:0] REG_ORDER [3] = '{REG_THRESHOLD, REG_OBJ_WIDTH, REG_FOCAL};

	// one frame result as the block reports it
	typedef struct packed {
		bit                found;
		bit [PWID_W-1:0]   width;
		bit [DIST_W-1:0]   distance;
	} frame_est_t;

	localparam frame_est_t NO_OBJECT = '0;

	// directed stimulus: a pixel transaction or a register write
	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [CIDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]  wdata;
		bit [PIX_W-1:0]    pix;
		bit                le;
		bit                fe;
		bit                typed;   // result below is typed in, else predicted
		frame_est_t        est;
	} row_t;

	localparam int DIR_ROWS = 35;
	localparam row_t DIRECTED [DIR_ROWS] = '{
		// reset settings (threshold 30, width 5 cm, focal 400): one dark pixel frame
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd0,   1'b0, 1'b1, 1'b1, NO_OBJECT},
		// bright at columns 0, 1 and 3, pixel equal to threshold stays dark,
		// frame end together with line end
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd255, 1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd31,  1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd30,  1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd31,  1'b1, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd255, 1'b1, 1'b1, 1'b0, NO_OBJECT},
		// single bright column is no object
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd200, 1'b0, 1'b1, 1'b1, NO_OBJECT},
		// bright pixel on the frame end transaction still widens the extent
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd40,  1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd5,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd99,  1'b0, 1'b1, 1'b1,
			'{1'b1, 12'd2, 28'd256000}},
		// threshold 255 after masking: nothing can be bright
		'{ROW_WRITE, REG_THRESHOLD, 16'hFFFF, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd255, 1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd255, 1'b0, 1'b1, 1'b1, NO_OBJECT},
		// threshold 0, widest object, longest focal: largest distance
		'{ROW_WRITE, REG_THRESHOLD, 16'h0100, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_WRITE, REG_OBJ_WIDTH, 16'hFFFF, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_WRITE, REG_FOCAL,     16'h0FFF, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd1,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd0,   1'b1, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd1,   1'b0, 1'b1, 1'b1,
			'{1'b1, 12'd1, 28'd268365825}},
		// zero object width: found, distance zero
		'{ROW_WRITE, REG_OBJ_WIDTH, 16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd9,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd9,   1'b0, 1'b1, 1'b1,
			'{1'b1, 12'd1, 28'd0}},
		// focal masked down to zero: distance zero
		'{ROW_WRITE, REG_OBJ_WIDTH, 16'hFFFF, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_WRITE, REG_FOCAL,     16'hF000, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd7,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd7,   1'b0, 1'b1, 1'b1,
			'{1'b1, 12'd1, 28'd0}},
		// write past the register list is dropped, focal 1, threshold mid scale
		'{ROW_WRITE, REG_SPARE,     16'hAAAA, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_WRITE, REG_FOCAL,     16'h5001, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_WRITE, REG_THRESHOLD, 16'h0080, 8'd0,   1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd128, 1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd129, 1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd200, 1'b0, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd255, 1'b1, 1'b0, 1'b0, NO_OBJECT},
		'{ROW_ITEM,  REG_THRESHOLD, 16'h0000, 8'd128, 1'b0, 1'b1, 1'b0, NO_OBJECT}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [7:0] pixel
	logic                s_tuser;   // [0] line_end
	logic                s_tlast;   // frame_end
	logic                m_tvalid;
	logic                m_tready;
	logic [39:0]         m_tdata;   // [11:0] pixel_width, [39:12] distance_q8
	logic                m_tuser;   // [0] object_found
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;

	// local copy of the registers
	bit [PIX_W-1:0]      thr_q       = THRESHOLD_RST;
	bit [OBJ_W-1:0]      obj_width_q = OBJ_WIDTH_RST;
	bit [FOCAL_W-1:0]    focal_q     = FOCAL_RST;

	// local copy of the scan state
	bit [PWID_W-1:0]     scan_col       = '0;
	bit [PWID_W-1:0]     min_bright_col = PWID_W'(LINE_W);
	bit [PWID_W-1:0]     max_bright_col = '0;

	// frame results still owed by the block, oldest first
	frame_est_t          pending_frames [$];

	int                  fail_count    = 0;
	bit                  calm          = 1'b0;   // no idling on either side

	threshold_extent_distance_core #(
		.LINE_WIDTH (LINE_W)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// track the bright extent for one pixel, return 1 with the estimate on frame end
	function automatic bit estimate_pixel(input bit [PIX_W-1:0] pix, input bit le,
			input bit fe, output frame_est_t est);
		bit [PWID_W-1:0] w;
		bit [DIST_W-1:0] prod;
		est = NO_OBJECT;
		// the pixel is looked at before the column moves on
		if (pix > thr_q) begin
			if (scan_col < min_bright_col)
				min_bright_col = scan_col;
			if (scan_col > max_bright_col)
				max_bright_col = scan_col;
		end
		// frame end also ends the line, long lines stick at the last column
		if (le || fe)
			scan_col = '0;
		else if (scan_col < PWID_W'(LINE_W - 1))
			scan_col = scan_col + 1'b1;
		if (!fe)
			return 1'b0;
		if (min_bright_col < max_bright_col) begin
			w = max_bright_col - min_bright_col;
			prod = DIST_W'(obj_width_q) * DIST_W'(focal_q);
			est.found = 1'b1;
			est.width = w;
			est.distance = prod / DIST_W'(w);
		end
		min_bright_col = PWID_W'(LINE_W);
		max_bright_col = '0;
		return 1'b1;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit [PIX_W-1:0] bright_px();
		if (thr_q == '1)
			return '1;
		return PIX_W'($urandom_range(thr_q + 1, 255));
	endfunction

	function automatic bit [PIX_W-1:0] dark_px();
		return PIX_W'($urandom_range(0, thr_q));
	endfunction

	// register value for the random part, extremes weighted in,
	// bits above the register width are random and must be dropped
	function automatic logic [CFG_W-1:0] pick_reg_value(input logic [CIDX_W-1:0] idx);
		int r;
		logic [CFG_W-1:0] v;
		r = $urandom_range(0, 19);
		v = CFG_W'($urandom());
		case (idx)
			REG_THRESHOLD: begin
				if (r < 2)
					v[PIX_W-1:0] = '0;
				else if (r < 4)
					v[PIX_W-1:0] = '1;
				else if (r < 15)
					v[PIX_W-1:0] = PIX_W'($urandom_range(10, 90));
			end
			REG_OBJ_WIDTH: begin
				if (r < 2)
					v = '0;
				else if (r < 4)
					v = '1;
			end
			REG_FOCAL: begin
				if (r < 1)
					v[FOCAL_W-1:0] = '0;
				else if (r < 3)
					v[FOCAL_W-1:0] = 12'd1;
				else if (r < 5)
					v[FOCAL_W-1:0] = '1;
			end
			default: ;
		endcase
		return v;
	endfunction

	// wait until every owed result is back and the divider has gone quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write, only ever issued with the block idle
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		if (!cfg_we)
			drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: thr_q = data[PIX_W-1:0];
			REG_OBJ_WIDTH: obj_width_q = data[OBJ_W-1:0];
			REG_FOCAL:     focal_q = data[FOCAL_W-1:0];
			default: ;
		endcase
	endtask

	// one pixel transaction; on return tvalid is still high with the accepted data
	task automatic send_pixel(input bit [PIX_W-1:0] pix, input bit le, input bit fe,
			input bit typed, input frame_est_t typed_est);
		int gap;
		frame_est_t est;
		gap = pick_gap();
		if (cfg_we)
			cfg_we <= 1'b0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= pix;
		s_tuser <= le;
		s_tlast <= fe;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		if (estimate_pixel(pix, le, fe, est))
			pending_frames.push_back(typed ? typed_est : est);
	endtask

	// one frame of short lines, the first over-long when asked; mostly a bright span over the same columns,
	// sometimes noise around the threshold or all dark
	task automatic send_frame(input bit long_line, output int n_sent);
		int n_lines, len, span_lo, span_hi, mode, l, c, r;
		bit lit, last_line, last_px;
		bit [PIX_W-1:0] pix;
		n_sent = 0;
		n_lines = long_line ? $urandom_range(1, 2) : $urandom_range(1, 4);
		mode = $urandom_range(0, 9);
		if (long_line) begin
			span_lo = $urandom_range(0, 600);
			span_hi = span_lo + $urandom_range(0, 100);
		end else begin
			span_lo = $urandom_range(0, 10);
			span_hi = span_lo + $urandom_range(0, 12);
		end
		for (l = 0; l < n_lines; l++) begin
			len = $urandom_range(1, 20);
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(21, 80);
			// first line runs past the line width so the column saturates
			if (long_line && l == 0)
				len = $urandom_range(LINE_W + 1, LINE_W + 60);
			lit = $urandom_range(0, 3) != 0;
			last_line = (l == n_lines - 1);
			for (c = 0; c < len; c++) begin
				last_px = (c == len - 1);
				if (mode < 6) begin
					pix = (lit && c >= span_lo && c <= span_hi) ? bright_px() : dark_px();
				end else if (mode < 9) begin
					r = $urandom_range(0, 3);
					if (r == 0)
						pix = thr_q;
					else if (r == 1)
						pix = thr_q + 1'b1;
					else
						pix = PIX_W'($urandom());
				end else begin
					pix = dark_px();
				end
				// frame end comes with or without its line end
				send_pixel(pix, last_px && (!last_line || $urandom_range(0, 1) == 1),
					last_px && last_line, 1'b0, NO_OBJECT);
				n_sent++;
			end
		end
	endtask

	// result checker: every result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		frame_est_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_frames.size() == 0) begin
				$error("result transaction with no frame pending");
				fail_count++;
			end else begin
				want = pending_frames.pop_front();
				if (m_tuser !== want.found) begin
					$error("object_found: expected %0d, got %0d", want.found, m_tuser);
					fail_count++;
				end
				if (m_tdata[11:0] !== want.width) begin
					$error("pixel_width: expected %0d, got %0d", want.width, m_tdata[11:0]);
					fail_count++;
				end
				if (m_tdata[39:12] !== want.distance) begin
					$error("distance_q8: expected %0d, got %0d", want.distance,
						m_tdata[39:12]);
					fail_count++;
				end
			end
		end
	end

	// result side backpressure: ready runs broken by stalls of random length
	initial begin : result_sink
		int run, stall;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= 1'b1;
			run = $urandom_range(1, 8);
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end
		end
	end

	// pixel side: reset, directed table, then random phases of frames
	initial begin : pixel_source
		int i, k, start, n_frames, f, n, phase, sent_items;
		row_t row;
		logic [CIDX_W-1:0] idx;
		bit long_line;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_WRITE)
				write_reg(row.reg_idx, row.wdata);
			else
				send_pixel(row.pix, row.le, row.fe, row.typed, row.est);
		end

		// each phase: new settings in random order, then a few frames;
		// the first phase carries one frame with an over-long line
		phase = 0;
		sent_items = 0;
		while (sent_items < ITEM_TARGET) begin
			phase++;
			start = $urandom_range(0, 2);
			for (k = 0; k < 3; k++) begin
				idx = REG_ORDER[(start + k) % 3];
				write_reg(idx, pick_reg_value(idx));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, CFG_W'($urandom()));
			calm = $urandom_range(0, 4) == 0;
			n_frames = $urandom_range(2, 6);
			for (f = 0; f < n_frames; f++) begin
				long_line = phase == 1 && f == 0;
				send_frame(long_line, n);
				sent_items += n;
			end
		end

		// let the last results come back, then give the block time for strays
		calm = 1'b0;
		if (cfg_we)
			cfg_we <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hard stop in case a handshake never completes
	initial begin : watchdog
		#(TIMEOUT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
